@@ rtl/core/trs_pkg.sv @@
// shared types and constants for the track regression statistics block
// no dependencies
package trs_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int NUM_STATS      = 27;
  localparam int STAT_IDX_W     = $clog2(NUM_STATS);
  localparam int ARITH_W        = 128;
  localparam int REG_W          = 24;
  localparam int REG_IDX_W      = 1;

  localparam logic [REG_IDX_W-1:0] REG_TIME_BIN = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FREQ_BIN = 1'd1;

  typedef struct packed {
    logic [23:0]        time_in_run;
    logic [23:0]        time_in_acq;
    logic [15:0]        acquisition_id;
    logic [23:0]        frequency;
    logic [15:0]        nsp;
    logic signed [11:0] amplitude;
    logic signed [15:0] local_slope;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [4:0]         stat_code;
    logic signed [63:0] stat_value;
    logic               last_stat;
  } stat_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef enum logic [4:0] {
    ST_NXY, ST_SXSY, ST_NXX, ST_SXSX, ST_SLOPE, ST_ICPT, ST_NN,
    ST_MEAN0, ST_NSQ0, ST_MM0, ST_VAR0, ST_DEV0,
    ST_MEAN1, ST_NSQ1, ST_MM1, ST_VAR1, ST_DEV1,
    ST_MEAN2, ST_NSQ2, ST_MM2, ST_VAR2, ST_DEV2,
    ST_TBIN, ST_FBIN, ST_NSPL
  } step_t;

  typedef struct packed {
    logic                  capture;
    logic                  square;
    logic                  accum;
    logic                  snap;
    logic                  issue;
    logic                  load_out;
    logic                  clear;
    step_t                 step;
    logic [STAT_IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_point;
    logic arith_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/track_regression_stats.sv @@
// track regression statistics: each point is captured, squared and accumulated before the next is taken
// after the last point a fixed sequence of 25 steps runs on one shared bit-serial unit,
// each step a multiply, divide or square root
// the 27 results then leave one per cycle through an output register, unless out_stall holds it
// synchronous reset clears the controller, accumulators and bin widths (to 1)
// depends on trs_pkg, trs_ctrl, trs_datapath
module track_regression_stats #(
  parameter int MAX_POINTS = trs_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  trs_pkg::point_t                in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output trs_pkg::stat_t                 out_data,
  input  logic                           cfg_write,
  input  logic [trs_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [trs_pkg::REG_W-1:0]      cfg_data
);
  import trs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  trs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  trs_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/trs_arith.sv @@
// iterative multiply, divide and square root unit, one bit step per cycle
// depends on trs_pkg
module trs_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  trs_pkg::arith_op_t            op,
  input  logic [trs_pkg::ARITH_W-1:0]   opa,
  input  logic [trs_pkg::ARITH_W-1:0]   opb,
  output logic                          done,
  output logic [trs_pkg::ARITH_W-1:0]   quot,
  output logic [trs_pkg::ARITH_W-1:0]   rem
);
  import trs_pkg::*;

  localparam int MUL_STEPS  = ARITH_W / 2;
  localparam int DIV_STEPS  = ARITH_W;
  localparam int SQRT_STEPS = ARITH_W / 4;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  logic               busy;
  arith_op_t          cur_op;
  logic [CNT_W-1:0]   cnt;
  logic [ARITH_W-1:0] acc;
  logic [ARITH_W:0]   rr;
  logic [ARITH_W-1:0] nn;
  logic [ARITH_W-1:0] dd;

  logic [ARITH_W:0]   rs;
  logic [63:0]        sq_sum;

  always_comb begin
    rs     = {rr[ARITH_W-1:0], nn[ARITH_W-1]};
    sq_sum = acc[63:0] + dd[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy   <= 1'b1;
        cur_op <= op;
        acc    <= '0;
        rr     <= '0;
        case (op)
          OP_MUL: begin
            nn  <= opa;
            dd  <= opb;
            cnt <= CNT_W'(MUL_STEPS - 1);
          end
          OP_DIV: begin
            nn  <= opa;
            dd  <= opb;
            cnt <= CNT_W'(DIV_STEPS - 1);
          end
          OP_SQRT: begin
            nn  <= ARITH_W'(opa[63:0]);
            dd  <= ARITH_W'(64'd1 << 62);
            cnt <= CNT_W'(SQRT_STEPS - 1);
          end
          default: begin
            nn  <= '0;
            dd  <= '0;
            cnt <= '0;
          end
        endcase
      end else if (busy) begin
        if (cnt == '0) busy <= 1'b0;
        cnt <= cnt - 1'b1;
        case (cur_op)
          OP_MUL: begin
            if (nn[0]) acc <= acc + dd;
            dd <= dd << 1;
            nn <= nn >> 1;
          end
          OP_DIV: begin
            if (rs >= {1'b0, dd}) begin
              rr  <= rs - {1'b0, dd};
              acc <= {acc[ARITH_W-2:0], 1'b1};
            end else begin
              rr  <= rs;
              acc <= {acc[ARITH_W-2:0], 1'b0};
            end
            nn <= nn << 1;
          end
          OP_SQRT: begin
            if (nn[63:0] >= sq_sum) begin
              nn  <= ARITH_W'(nn[63:0] - sq_sum);
              acc <= (acc >> 1) + dd;
            end else begin
              acc <= acc >> 1;
            end
            dd <= dd >> 2;
          end
          default: begin
            acc <= acc;
          end
        endcase
      end
    end
  end

  assign quot = acc;
  assign rem  = rr[ARITH_W-1:0];

endmodule

@@ rtl/core/trs_datapath.sv @@
// accumulators, statistic store, output register and final arithmetic operands and write-back
// depends on trs_pkg and trs_arith
module trs_datapath #(
  parameter int MAX_POINTS = trs_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  trs_pkg::point_t                 in_data,
  input  logic                            cfg_write,
  input  logic [trs_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [trs_pkg::REG_W-1:0]       cfg_data,
  input  trs_pkg::ctrl_cmd_t              cmd,
  output trs_pkg::dp_status_t             status,
  input  logic                            out_stall,
  output logic                            out_valid,
  output trs_pkg::stat_t                  out_data
);
  import trs_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int TS_W  = 24 + CNT_W;
  localparam int TT_W  = 48 + CNT_W;
  localparam int SUM_W = 24 + CNT_W;
  localparam int SQ_W  = 46 + CNT_W;
  localparam int NN_W  = 2 * CNT_W;
  localparam int MAN_W = 27;
  localparam int STATS_PER_Q = 4;

  localparam logic [1:0] Q_LS  = 2'd0;
  localparam logic [1:0] Q_NSP = 2'd1;
  localparam logic [1:0] Q_PW  = 2'd2;

  localparam int OFS_DEV = 1;
  localparam int OFS_MIN = 2;
  localparam int OFS_MAX = 3;

  localparam logic [4:0] SC_T0      = 5'd0;
  localparam logic [4:0] SC_T1      = 5'd1;
  localparam logic [4:0] SC_TLEN    = 5'd2;
  localparam logic [4:0] SC_A0      = 5'd3;
  localparam logic [4:0] SC_A1      = 5'd4;
  localparam logic [4:0] SC_ID0     = 5'd5;
  localparam logic [4:0] SC_F0      = 5'd6;
  localparam logic [4:0] SC_F1      = 5'd7;
  localparam logic [4:0] SC_FLEN    = 5'd8;
  localparam logic [4:0] SC_SLOPE   = 5'd9;
  localparam logic [4:0] SC_ICPT    = 5'd10;
  localparam logic [4:0] SC_LS_MEAN = 5'd11;
  localparam logic [4:0] SC_TOT_NSP = 5'd23;
  localparam logic [4:0] SC_TOT_PW  = 5'd24;
  localparam logic [4:0] SC_MAN     = 5'd25;
  localparam logic [4:0] SC_NSP_LEN = 5'd26;

  function automatic logic [1:0] qidx(input step_t s);
    case (s)
      ST_MEAN0, ST_NSQ0, ST_MM0, ST_VAR0, ST_DEV0: return Q_LS;
      ST_MEAN1, ST_NSQ1, ST_MM1, ST_VAR1, ST_DEV1: return Q_NSP;
      ST_MEAN2, ST_NSQ2, ST_MM2, ST_VAR2, ST_DEV2: return Q_PW;
      default: return Q_LS;
    endcase
  endfunction

  function automatic logic [4:0] qstat(input logic [1:0] k, input int ofs);
    return 5'(int'(SC_LS_MEAN) + STATS_PER_Q * int'(k) + ofs);
  endfunction

  function automatic logic [ARITH_W-1:0] floor_fix(input logic [ARITH_W-1:0] q,
                                                   input logic [ARITH_W-1:0] r,
                                                   input logic neg);
    return neg ? (-q - ARITH_W'(|r)) : q;
  endfunction

  function automatic logic [63:0] sat64(input logic [ARITH_W-1:0] v);
    if (&v[ARITH_W-1:63] || ~|v[ARITH_W-1:63]) return v[63:0];
    return v[ARITH_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  point_t                  pt;
  logic [22:0]             pw;
  logic [CNT_W-1:0]        count;
  logic [23:0]             t0, a0, f0, t1, f1;
  logic [15:0]             id0;
  logic [TS_W-1:0]         tsum, fsum;
  logic [TT_W-1:0]         ttsum, tfsum;
  logic signed [SUM_W-1:0] qsum [3];
  logic [SQ_W-1:0]         qsq [3];
  logic signed [23:0]      qmin [3];
  logic signed [23:0]      qmax [3];
  logic [REG_W-1:0]        tbw, fbw;
  logic [ARITH_W-1:0]      tmp_a, tmp_b;
  logic [63:0]             slope;
  logic [NN_W-1:0]         nn;
  logic signed [MAN_W-1:0] man;
  logic [63:0]             stat [NUM_STATS];

  logic signed [23:0]      qv [3];
  logic [22:0]             qm [3];
  logic [45:0]             qprod [3];
  logic signed [23:0]      amp_sq;
  logic [47:0]             tt_prod, tf_prod;
  logic signed [24:0]      tlen, flen;
  logic signed [25:0]      a1;
  logic [23:0]             tmag, fmag;
  logic [REG_W-1:0]        tb, fb;
  logic [MAN_W-1:0]        man_mag;
  logic [ARITH_W-1:0]      n128, num_mag;
  logic [63:0]             slope_mag;
  logic [ARITH_W-1:0]      smag [3];
  logic [1:0]              qk;

  arith_op_t               a_op;
  logic [ARITH_W-1:0]      a_opa, a_opb;
  logic                    a_done;
  logic [ARITH_W-1:0]      res_q, res_r;

  logic [63:0]             wb_slope, wb_icpt, wb_mean, wb_nspl;
  logic signed [MAN_W-1:0] wb_bin, man_sum;
  logic                    bin_neg;

  always_comb begin
    amp_sq  = pt.amplitude * pt.amplitude;
    qv[0]   = 24'(pt.local_slope);
    qv[1]   = $signed({8'd0, pt.nsp});
    qv[2]   = $signed({1'b0, pw});
    for (int k = 0; k < 3; k++) begin
      qm[k]    = qv[k] < 0 ? 23'(-qv[k]) : 23'(qv[k]);
      qprod[k] = qm[k] * qm[k];
      smag[k]  = qsum[k] < 0 ? ARITH_W'(-qsum[k]) : ARITH_W'(qsum[k]);
    end
    tt_prod   = pt.time_in_run * pt.time_in_run;
    tf_prod   = pt.time_in_run * pt.frequency;
    tlen      = $signed({1'b0, t1}) - $signed({1'b0, t0});
    flen      = $signed({1'b0, f1}) - $signed({1'b0, f0});
    a1        = 26'($signed({1'b0, a0})) + 26'(tlen);
    tmag      = tlen < 0 ? 24'(-tlen) : 24'(tlen);
    fmag      = flen < 0 ? 24'(-flen) : 24'(flen);
    tb        = (tbw == '0) ? REG_W'(1) : tbw;
    fb        = (fbw == '0) ? REG_W'(1) : fbw;
    man_mag   = man < 0 ? MAN_W'(-man) : MAN_W'(man);
    n128      = ARITH_W'(count);
    num_mag   = tmp_a[ARITH_W-1] ? -tmp_a : tmp_a;
    slope_mag = slope[63] ? -slope : slope;
    qk        = qidx(cmd.step);
  end

  // operand selection for the current step
  always_comb begin
    a_op  = OP_MUL;
    a_opa = '0;
    a_opb = '0;
    case (cmd.step)
      ST_NXY: begin
        a_opa = n128;
        a_opb = ARITH_W'(tfsum);
      end
      ST_SXSY: begin
        a_opa = ARITH_W'(tsum);
        a_opb = ARITH_W'(fsum);
      end
      ST_NXX: begin
        a_opa = n128;
        a_opb = ARITH_W'(ttsum);
      end
      ST_SXSX: begin
        a_opa = ARITH_W'(tsum);
        a_opb = ARITH_W'(tsum);
      end
      ST_SLOPE: begin
        a_op  = OP_DIV;
        a_opa = num_mag << 32;
        a_opb = tmp_b;
      end
      ST_ICPT: begin
        a_opa = ARITH_W'(slope_mag);
        a_opb = ARITH_W'(a0);
      end
      ST_NN: begin
        a_opa = n128;
        a_opb = n128;
      end
      ST_MEAN0, ST_MEAN1, ST_MEAN2: begin
        a_op  = OP_DIV;
        a_opa = smag[qk];
        a_opb = n128;
      end
      ST_NSQ0, ST_NSQ1, ST_NSQ2: begin
        a_opa = n128;
        a_opb = ARITH_W'(qsq[qk]);
      end
      ST_MM0, ST_MM1, ST_MM2: begin
        a_opa = smag[qk];
        a_opb = smag[qk];
      end
      ST_VAR0, ST_VAR1, ST_VAR2: begin
        a_op  = OP_DIV;
        a_opa = tmp_a;
        a_opb = ARITH_W'(nn);
      end
      ST_DEV0, ST_DEV1, ST_DEV2: begin
        a_op  = OP_SQRT;
        a_opa = tmp_a;
      end
      ST_TBIN: begin
        a_op  = OP_DIV;
        a_opa = (ARITH_W'(tmag) << 1) + ARITH_W'(tb);
        a_opb = ARITH_W'(tb) << 1;
      end
      ST_FBIN: begin
        a_op  = OP_DIV;
        a_opa = (ARITH_W'(fmag) << 1) + ARITH_W'(fb);
        a_opb = ARITH_W'(fb) << 1;
      end
      ST_NSPL: begin
        a_op  = OP_DIV;
        a_opa = ARITH_W'(smag[Q_NSP]) << 25;
        a_opb = ARITH_W'(man_mag);
      end
      default: begin
        a_op = OP_MUL;
      end
    endcase
  end

  trs_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.issue),
    .op    (a_op),
    .opa   (a_opa),
    .opb   (a_opb),
    .done  (a_done),
    .quot  (res_q),
    .rem   (res_r)
  );

  always_comb begin
    wb_slope = (count < CNT_W'(2) || tmp_b[ARITH_W-1] || tmp_b == '0) ? 64'd0 :
               sat64(floor_fix(res_q, res_r, tmp_a[ARITH_W-1]));
    wb_icpt  = (count < CNT_W'(2)) ? 64'd0 :
               sat64((ARITH_W'(f0) << 32) - (slope[63] ? -res_q : res_q));
    wb_mean  = 64'(floor_fix(res_q, res_r, qsum[qk] < 0));
    bin_neg  = (cmd.step == ST_TBIN) ? (tlen < 0) : (flen < 0);
    wb_bin   = bin_neg ? -$signed(MAN_W'(res_q)) : $signed(MAN_W'(res_q));
    man_sum  = man + wb_bin;
    wb_nspl  = (man == '0) ? 64'd0 : 64'(floor_fix(res_q, res_r, man < 0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbw <= REG_W'(1);
      fbw <= REG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_BIN: tbw <= cfg_data;
        REG_FREQ_BIN: fbw <= cfg_data;
        default: tbw <= tbw;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) pt <= in_data;
    if (cmd.square) pw <= amp_sq[22:0];
  end

  // per point accumulation
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      tsum  <= '0;
      fsum  <= '0;
      ttsum <= '0;
      tfsum <= '0;
      for (int k = 0; k < 3; k++) begin
        qsum[k] <= '0;
        qsq[k]  <= '0;
        qmin[k] <= '0;
        qmax[k] <= '0;
      end
    end else if (cmd.accum && count < CNT_W'(MAX_POINTS)) begin
      if (count == '0) begin
        t0  <= pt.time_in_run;
        a0  <= pt.time_in_acq;
        id0 <= pt.acquisition_id;
        f0  <= pt.frequency;
      end
      t1    <= pt.time_in_run;
      f1    <= pt.frequency;
      count <= count + 1'b1;
      tsum  <= tsum + TS_W'(pt.time_in_run);
      fsum  <= fsum + TS_W'(pt.frequency);
      ttsum <= ttsum + TT_W'(tt_prod);
      tfsum <= tfsum + TT_W'(tf_prod);
      for (int k = 0; k < 3; k++) begin
        qsum[k] <= qsum[k] + SUM_W'(qv[k]);
        qsq[k]  <= qsq[k] + SQ_W'(qprod[k]);
        if (count == '0 || qv[k] < qmin[k]) qmin[k] <= qv[k];
        if (count == '0 || qv[k] > qmax[k]) qmax[k] <= qv[k];
      end
    end
  end

  // final statistics
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      stat[SC_T0]      <= 64'(t0);
      stat[SC_T1]      <= 64'(t1);
      stat[SC_TLEN]    <= 64'(tlen);
      stat[SC_A0]      <= 64'(a0);
      stat[SC_A1]      <= 64'(a1);
      stat[SC_ID0]     <= 64'(id0);
      stat[SC_F0]      <= 64'(f0);
      stat[SC_F1]      <= 64'(f1);
      stat[SC_FLEN]    <= 64'(flen);
      stat[SC_TOT_NSP] <= 64'(qsum[Q_NSP]);
      stat[SC_TOT_PW]  <= 64'(qsum[Q_PW]);
      for (int k = 0; k < 3; k++) begin
        stat[qstat(2'(k), OFS_MIN)] <= 64'(qmin[k]);
        stat[qstat(2'(k), OFS_MAX)] <= 64'(qmax[k]);
      end
      man <= '0;
    end else if (a_done) begin
      case (cmd.step)
        ST_NXY:  tmp_a <= res_q;
        ST_SXSY: tmp_a <= tmp_a - res_q;
        ST_NXX:  tmp_b <= res_q;
        ST_SXSX: tmp_b <= tmp_b - res_q;
        ST_SLOPE: begin
          slope          <= wb_slope;
          stat[SC_SLOPE] <= wb_slope;
        end
        ST_ICPT: stat[SC_ICPT] <= wb_icpt;
        ST_NN:   nn <= res_q[NN_W-1:0];
        ST_MEAN0, ST_MEAN1, ST_MEAN2: stat[qstat(qk, 0)] <= wb_mean;
        ST_NSQ0, ST_NSQ1, ST_NSQ2: tmp_a <= res_q;
        ST_MM0, ST_MM1, ST_MM2: tmp_a <= (tmp_a > res_q) ? tmp_a - res_q : '0;
        ST_VAR0, ST_VAR1, ST_VAR2: tmp_a <= res_q;
        ST_DEV0, ST_DEV1, ST_DEV2: stat[qstat(qk, OFS_DEV)] <= res_q[63:0];
        ST_TBIN: man <= wb_bin;
        ST_FBIN: begin
          man          <= man_sum;
          stat[SC_MAN] <= 64'(man_sum);
        end
        ST_NSPL: stat[SC_NSP_LEN] <= wb_nspl;
        default: tmp_a <= tmp_a;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.stat_code  <= 5'(cmd.idx);
      out_data.stat_value <= stat[cmd.idx];
      out_data.last_stat  <= (cmd.idx == STAT_IDX_W'(NUM_STATS - 1));
    end
  end

  always_comb begin
    status.last_point = pt.last_point;
    status.arith_done = a_done;
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

@@ rtl/core/trs_ctrl.sv @@
// controller: point intake, final step sequencing and result emission
// depends on trs_pkg
module trs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  trs_pkg::dp_status_t status,
  output trs_pkg::ctrl_cmd_t  cmd
);
  import trs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_ACC,
    S_SNAP,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t                state;
  step_t                 step;
  logic [STAT_IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= ST_NXY;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_SQR;
        S_SQR:  state <= S_ACC;
        S_ACC:  state <= status.last_point ? S_SNAP : S_IDLE;
        S_SNAP: begin
          step  <= ST_NXY;
          state <= S_ISSUE;
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (status.arith_done) begin
            if (step == ST_NSPL) begin
              idx   <= '0;
              state <= S_EMIT;
            end else begin
              step  <= step_t'(step + 1'b1);
              state <= S_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (status.out_free) begin
            if (idx == STAT_IDX_W'(NUM_STATS - 1)) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_stall     = (state != S_IDLE);
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.square   = (state == S_SQR);
    cmd.accum    = (state == S_ACC);
    cmd.snap     = (state == S_SNAP);
    cmd.issue    = (state == S_ISSUE);
    cmd.load_out = (state == S_EMIT) && status.out_free;
    cmd.clear    = cmd.load_out && (idx == STAT_IDX_W'(NUM_STATS - 1));
    cmd.step     = step;
    cmd.idx      = idx;
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded into a full output register");

  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    status.arith_done |-> (state == S_WAIT))
    else $error("arithmetic unit finished outside a wait");

  a_snap_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SNAP) |-> $past(status.last_point))
    else $error("final sequence started without a last point");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (state == S_IDLE))
    else $error("track cleared before emission finished");
`endif

endmodule
